>>> hdl/rpu_pkg.sv
// ----------------------------------------------------------------------------
// rpu_pkg
// Shared types and constants of the readout packet unpacker: record kinds,
// channel word type codes, controller states and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package rpu_pkg;

  // Fixed packet layout
  localparam int HDR_WORDS   = 5;   // flag, module, event, beam clock, detector id
  localparam int SEARCH_SPAN = 19;  // userword search looks at the last words only
  localparam int USER_BIT    = 28;  // marks the first userword
  localparam int CH_WIDTH    = 7;   // channel field in a channel word
  localparam int CH_LSB      = 20;
  localparam int TY_LSB      = 16;

  // Channel word type codes
  localparam logic [3:0] TYPE_CHARGE = 4'ha;
  localparam logic [3:0] TYPE_TIME1  = 4'hc;
  localparam logic [3:0] TYPE_TIME2  = 4'hb;

  // Output record kinds
  typedef enum logic [1:0] {
    KIND_HDR_A = 2'd0,
    KIND_HDR_B = 2'd1,
    KIND_CHAN  = 2'd2,
    KIND_BOARD = 2'd3
  } rec_kind_t;

  // Controller states
  typedef enum logic [3:0] {
    S_RECV,
    S_SRCH_INIT,
    S_SRCH_ADDR,
    S_SRCH_TEST,
    S_HDR_A,
    S_HDR_B,
    S_CH_RD,
    S_CH_OUT,
    S_BD_RD,
    S_BD_OUT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic      capture;     // take the incoming word
    logic      srch_init;   // load search index with window start
    logic      srch_read;   // read buffer at search index
    logic      srch_adv;    // step search index
    logic      chan_read;   // read channel tables at record index
    logic      board_read;  // read buffer at search index + record index
    logic      idx_clr;
    logic      idx_inc;
    logic      load;        // load output register
    logic      last;        // final record of the run
    logic      finish;      // clear per-packet state
    rec_kind_t kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic srch_more;   // search index still inside the window
    logic hit;         // word just read is a userword
    logic out_free;    // output register can take a record
    logic chan_last;   // record index on the last channel
    logic board_last;  // record index on the last board slot
  } sts_t;

endpackage

>>> hdl/rpu_datapath.sv
// ----------------------------------------------------------------------------
// rpu_datapath
// Word buffer, header capture, channel tables, userword search index,
// record counter and the output record register.
// ----------------------------------------------------------------------------
module rpu_datapath import rpu_pkg::*; #(
  parameter int MAX_WORDS = 128,
  parameter int CHANNELS  = 32,
  parameter int BOARD_IDS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [31:0] packet_word,
  input  logic        record_ready,
  output logic        record_valid,
  output logic [1:0]  record_kind,
  output logic [4:0]  index,
  output logic [15:0] word_a,
  output logic [15:0] word_b,
  output logic [15:0] word_c,
  output logic [15:0] word_d,
  output logic        overflow,
  output logic        last_of_packet
);

  localparam int CW   = $clog2(MAX_WORDS + 1);
  localparam int AW   = $clog2(MAX_WORDS);
  localparam int CHW  = $clog2(CHANNELS);
  localparam int RMAX = (CHANNELS > BOARD_IDS) ? CHANNELS : BOARD_IDS;
  localparam int RW   = $clog2(RMAX);
  localparam int SW   = ((CW > RW) ? CW : RW) + 1;

  // Packet state
  logic [CW-1:0]       word_count;
  logic                scanning;
  logic                overflow_flag;
  logic [15:0]         hdr_word [HDR_WORDS];
  logic [15:0]         w_last;
  logic [15:0]         w_prev;
  logic [CHANNELS-1:0] chg_vld;
  logic [CHANNELS-1:0] t1_vld;
  logic [CHANNELS-1:0] t2_vld;

  // Search and record counters
  logic [CW-1:0] srch_i;
  logic [RW-1:0] rec_idx;

  // Memories and their read registers
  logic [31:0] word_mem [MAX_WORDS];
  logic [15:0] chg_mem  [CHANNELS];
  logic [15:0] t1_mem   [CHANNELS];
  logic [15:0] t2_mem   [CHANNELS];
  logic [31:0] mem_q;
  logic        bd_vld_q;
  logic [15:0] chg_q, t1_q, t2_q;
  logic        chg_vld_q, t1_vld_q, t2_vld_q;

  // Output register
  logic        out_valid;
  rec_kind_t   out_kind;
  logic [4:0]  out_index;
  logic [15:0] out_a, out_b, out_c, out_d;
  logic        out_ovf, out_last;

  // Decoded incoming word
  logic                store;
  logic [CH_WIDTH-1:0] ch_num;
  logic [3:0]          ch_type;
  logic                scan_word;
  logic                tbl_we;
  logic [CHW-1:0]      ch_addr;
  logic [CHW-1:0]      rd_ch;

  // Derived values
  logic [CW-1:0] win_start;
  logic [CW:0]   srch_end;
  logic [SW-1:0] bd_sum;
  logic [AW-1:0] rd_addr;
  logic [15:0]   board_count;
  logic          rd_en;

  assign store     = cmd.capture && (word_count < CW'(MAX_WORDS));
  assign ch_num    = packet_word[CH_LSB +: CH_WIDTH];
  assign ch_type   = packet_word[TY_LSB +: 4];
  assign scan_word = cmd.capture && scanning && (word_count >= CW'(HDR_WORDS));
  assign tbl_we    = scan_word && (packet_word[31:28] == 4'h0)
                     && (32'(ch_num) < CHANNELS);
  assign ch_addr   = CHW'(ch_num);
  assign rd_ch     = CHW'(rec_idx);

  assign win_start   = (word_count > CW'(SEARCH_SPAN)) ? word_count - CW'(SEARCH_SPAN) : '0;
  assign srch_end    = {1'b0, srch_i} + (CW+1)'(2);
  assign bd_sum      = SW'(srch_i) + SW'(rec_idx);
  assign rd_en       = cmd.srch_read || cmd.board_read;
  assign rd_addr     = cmd.srch_read ? AW'(srch_i) : AW'(bd_sum);
  assign board_count = (srch_end < {1'b0, word_count})
                       ? 16'(word_count - srch_i - CW'(2)) : 16'h0;

  // Status back to the controller
  assign sts.srch_more  = srch_end < {1'b0, word_count};
  assign sts.hit        = mem_q[USER_BIT];
  assign sts.out_free   = !out_valid || record_ready;
  assign sts.chan_last  = rec_idx == RW'(CHANNELS - 1);
  assign sts.board_last = rec_idx == RW'(BOARD_IDS - 1);

  // Per-packet control state
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      word_count    <= '0;
      scanning      <= 1'b1;
      overflow_flag <= 1'b0;
      w_last        <= '0;
      w_prev        <= '0;
      chg_vld       <= '0;
      t1_vld        <= '0;
      t2_vld        <= '0;
      for (int k = 0; k < HDR_WORDS; k++) begin
        hdr_word[k] <= '0;
      end
    end else if (cmd.capture) begin
      if (store) begin
        word_count <= word_count + CW'(1);
        w_last     <= packet_word[15:0];
        w_prev     <= w_last;
        for (int k = 0; k < HDR_WORDS; k++) begin
          if (word_count == CW'(k)) hdr_word[k] <= packet_word[15:0];
        end
      end else begin
        overflow_flag <= 1'b1;
      end
      if (scan_word && packet_word[31:28] != 4'h0) scanning <= 1'b0;
      if (tbl_we) begin
        if (ch_type == TYPE_CHARGE) chg_vld[ch_addr] <= 1'b1;
        if (ch_type == TYPE_TIME1)  t1_vld[ch_addr]  <= 1'b1;
        if (ch_type == TYPE_TIME2)  t2_vld[ch_addr]  <= 1'b1;
      end
    end
  end

  // Search index and record index
  always_ff @(posedge clk) begin
    if (rst) begin
      srch_i  <= '0;
      rec_idx <= '0;
    end else begin
      if (cmd.srch_init)     srch_i <= win_start;
      else if (cmd.srch_adv) srch_i <= srch_i + CW'(1);
      if (cmd.idx_clr)       rec_idx <= '0;
      else if (cmd.idx_inc)  rec_idx <= rec_idx + RW'(1);
    end
  end

  // Word buffer
  always_ff @(posedge clk) begin
    if (store) word_mem[AW'(word_count)] <= packet_word;
    if (rd_en) mem_q <= word_mem[rd_addr];
    if (cmd.board_read) bd_vld_q <= bd_sum < SW'(word_count);
  end

  // Channel tables
  always_ff @(posedge clk) begin
    if (tbl_we && ch_type == TYPE_CHARGE) chg_mem[ch_addr] <= packet_word[15:0];
    if (tbl_we && ch_type == TYPE_TIME1)  t1_mem[ch_addr]  <= packet_word[15:0];
    if (tbl_we && ch_type == TYPE_TIME2)  t2_mem[ch_addr]  <= packet_word[15:0];
    if (cmd.chan_read) begin
      chg_q     <= chg_mem[rd_ch];
      t1_q      <= t1_mem[rd_ch];
      t2_q      <= t2_mem[rd_ch];
      chg_vld_q <= chg_vld[rd_ch];
      t1_vld_q  <= t1_vld[rd_ch];
      t2_vld_q  <= t2_vld[rd_ch];
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (record_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: record fields by kind
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_kind <= cmd.kind;
      out_ovf  <= overflow_flag;
      out_last <= cmd.last;
      unique case (cmd.kind)
        KIND_HDR_A: begin
          out_index <= '0;
          out_a     <= hdr_word[4];
          out_b     <= hdr_word[2];
          out_c     <= hdr_word[1];
          out_d     <= hdr_word[0];
        end
        KIND_HDR_B: begin
          out_index <= '0;
          out_a     <= hdr_word[3];
          out_b     <= w_prev;
          out_c     <= w_last;
          out_d     <= board_count;
        end
        KIND_CHAN: begin
          out_index <= 5'(rec_idx);
          out_a     <= chg_vld_q ? chg_q : 16'h0;
          out_b     <= t1_vld_q ? t1_q : 16'h0;
          out_c     <= t2_vld_q ? t2_q : 16'h0;
          out_d     <= '0;
        end
        KIND_BOARD: begin
          out_index <= 5'(rec_idx);
          out_a     <= bd_vld_q ? mem_q[15:0] : 16'h0;
          out_b     <= '0;
          out_c     <= '0;
          out_d     <= '0;
        end
        default: begin
          out_index <= '0;
          out_a     <= '0;
          out_b     <= '0;
          out_c     <= '0;
          out_d     <= '0;
        end
      endcase
    end
  end

  assign record_valid   = out_valid;
  assign record_kind    = out_kind;
  assign index          = out_index;
  assign word_a         = out_a;
  assign word_b         = out_b;
  assign word_c         = out_c;
  assign word_d         = out_d;
  assign overflow       = out_ovf;
  assign last_of_packet = out_last;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    word_count <= CW'(MAX_WORDS))
    else $error("word count past buffer depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> word_count == CW'(MAX_WORDS))
    else $error("overflow set with room left in buffer");

  a_srch_window: assert property (@(posedge clk) disable iff (rst)
    cmd.srch_adv |-> sts.srch_more)
    else $error("search stepped outside its window");

endmodule

>>> hdl/rpu_ctrl.sv
// ----------------------------------------------------------------------------
// rpu_ctrl
// Controller: takes packet words, runs the userword search, then steps
// through the header, channel and board records of the run.
// ----------------------------------------------------------------------------
module rpu_ctrl import rpu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic word_valid,
  input  logic end_of_packet,
  output logic word_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RECV;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_RECV:      if (word_valid && end_of_packet) state_next = S_SRCH_INIT;
      S_SRCH_INIT: state_next = S_SRCH_ADDR;
      S_SRCH_ADDR: state_next = sts.srch_more ? S_SRCH_TEST : S_HDR_A;
      S_SRCH_TEST: state_next = sts.hit ? S_HDR_A : S_SRCH_ADDR;
      S_HDR_A:     if (sts.out_free) state_next = S_HDR_B;
      S_HDR_B:     if (sts.out_free) state_next = S_CH_RD;
      S_CH_RD:     state_next = S_CH_OUT;
      S_CH_OUT: begin
        if (sts.out_free) state_next = sts.chan_last ? S_BD_RD : S_CH_RD;
      end
      S_BD_RD:     state_next = S_BD_OUT;
      S_BD_OUT: begin
        if (sts.out_free) state_next = sts.board_last ? S_RECV : S_BD_RD;
      end
      default:     state_next = S_RECV;
    endcase
  end

  // Commands
  always_comb begin
    cmd        = '0;
    cmd.kind   = KIND_HDR_A;
    word_ready = 1'b0;
    unique case (state)
      S_RECV: begin
        word_ready  = 1'b1;
        cmd.capture = word_valid;
      end
      S_SRCH_INIT: cmd.srch_init = 1'b1;
      S_SRCH_ADDR: cmd.srch_read = sts.srch_more;
      S_SRCH_TEST: cmd.srch_adv  = !sts.hit;
      S_HDR_A: begin
        cmd.kind = KIND_HDR_A;
        cmd.load = sts.out_free;
      end
      S_HDR_B: begin
        cmd.kind    = KIND_HDR_B;
        cmd.load    = sts.out_free;
        cmd.idx_clr = 1'b1;
      end
      S_CH_RD: cmd.chan_read = 1'b1;
      S_CH_OUT: begin
        cmd.kind    = KIND_CHAN;
        cmd.load    = sts.out_free;
        cmd.idx_clr = sts.out_free && sts.chan_last;
        cmd.idx_inc = sts.out_free && !sts.chan_last;
      end
      S_BD_RD: cmd.board_read = 1'b1;
      S_BD_OUT: begin
        cmd.kind    = KIND_BOARD;
        cmd.load    = sts.out_free;
        cmd.last    = sts.board_last;
        cmd.finish  = sts.out_free && sts.board_last;
        cmd.idx_inc = sts.out_free && !sts.board_last;
      end
      default: ;
    endcase
  end

  // Checks
  c_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.out_free)
    else $error("record loaded over an untaken record");

  c_finish_last: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (cmd.load && cmd.last && cmd.kind == KIND_BOARD))
    else $error("packet state cleared before the final record");

endmodule

>>> hdl/readout_packet_unpacker.sv
// ----------------------------------------------------------------------------
// readout_packet_unpacker
// Buffers one readout packet word by word and unpacks it into header,
// channel and board records.
// ----------------------------------------------------------------------------
// Input channel (word_valid/word_ready): one 32-bit packet word per beat,
// end_of_packet high on the final word. Words are taken one per cycle
// while a packet is coming in; word_ready is low while a finished packet
// is being unpacked.
// Output channel (record_valid/record_ready): per packet, two header
// records, CHANNELS channel records and BOARD_IDS board records, the
// last one flagged by last_of_packet.
// After the final word of a packet the controller sets up the userword
// search, then tests each word in the window by a buffer read and a check
// (up to 17 words), with one more window check when no userword is found;
// then it loads each header record directly and each channel or board
// record by a table or buffer read, then a load of the output register.
// A stalled receiver holds the current record; unpacking pauses until it
// is taken. Reset empties the packet state and the output register.
// ----------------------------------------------------------------------------
module readout_packet_unpacker import rpu_pkg::*; #(
  parameter int MAX_WORDS = 128,
  parameter int CHANNELS  = 32,
  parameter int BOARD_IDS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        word_valid,
  output logic        word_ready,
  input  logic [31:0] packet_word,
  input  logic        end_of_packet,
  output logic        record_valid,
  input  logic        record_ready,
  output logic [1:0]  record_kind,
  output logic [4:0]  index,
  output logic [15:0] word_a,
  output logic [15:0] word_b,
  output logic [15:0] word_c,
  output logic [15:0] word_d,
  output logic        overflow,
  output logic        last_of_packet
);

  cmd_t cmd;
  sts_t sts;

  rpu_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .word_valid    (word_valid),
    .end_of_packet (end_of_packet),
    .word_ready    (word_ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  rpu_datapath #(
    .MAX_WORDS (MAX_WORDS),
    .CHANNELS  (CHANNELS),
    .BOARD_IDS (BOARD_IDS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .packet_word    (packet_word),
    .record_ready   (record_ready),
    .record_valid   (record_valid),
    .record_kind    (record_kind),
    .index          (index),
    .word_a         (word_a),
    .word_b         (word_b),
    .word_c         (word_c),
    .word_d         (word_d),
    .overflow       (overflow),
    .last_of_packet (last_of_packet)
  );

endmodule

>>> bench/tb_readout_packet_unpacker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_readout_packet_unpacker
// Drives readout packets into the unpacker one word at a time and checks
// every emitted header, channel and board record against a behavioral
// model kept in the bench. It covers short and truncated packets, channel
// words out of range, buffer overflow and a long output stall, under
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb_readout_packet_unpacker import rpu_pkg::*;;

  localparam int MAX_WORDS   = 128;
  localparam int CHANNELS    = 32;
  localparam int BOARD_IDS   = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    rec_kind_t   kind;
    logic [4:0]  idx;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [15:0] d;
    logic        ovf;
    logic        last;
  } unpacked_rec_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        word_valid    = 1'b0;
  logic        word_ready;
  logic [31:0] packet_word   = '0;
  logic        end_of_packet = 1'b0;
  logic        record_valid;
  logic        record_ready  = 1'b0;
  logic [1:0]  record_kind;
  logic [4:0]  index;
  logic [15:0] word_a;
  logic [15:0] word_b;
  logic [15:0] word_c;
  logic [15:0] word_d;
  logic        overflow;
  logic        last_of_packet;

  // Model state
  logic [31:0] mdl_words  [MAX_WORDS];
  logic [15:0] mdl_charge [CHANNELS];
  logic [15:0] mdl_time1  [CHANNELS];
  logic [15:0] mdl_time2  [CHANNELS];
  int          mdl_count;
  bit          mdl_scan;
  bit          mdl_ovf;

  unpacked_rec_t pending_records [$];
  logic [31:0]   pkt_words [$];

  // Run bookkeeping
  int bad_records     = 0;
  int records_checked = 0;
  int words_sent      = 0;
  int packets_sent    = 0;
  int cycle_count     = 0;

  // Idling controls
  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int rx_left = 0;
  int rx_pick;

  unpacked_rec_t got;
  unpacked_rec_t want;

  readout_packet_unpacker #(
    .MAX_WORDS (MAX_WORDS),
    .CHANNELS  (CHANNELS),
    .BOARD_IDS (BOARD_IDS)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .word_valid     (word_valid),
    .word_ready     (word_ready),
    .packet_word    (packet_word),
    .end_of_packet  (end_of_packet),
    .record_valid   (record_valid),
    .record_ready   (record_ready),
    .record_kind    (record_kind),
    .index          (index),
    .word_a         (word_a),
    .word_b         (word_b),
    .word_c         (word_c),
    .word_d         (word_d),
    .overflow       (overflow),
    .last_of_packet (last_of_packet)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records outstanding",
               cycle_count, pending_records.size());
      $display("FAIL readout_packet_unpacker");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  function automatic void model_clear_packet();
    for (int k = 0; k < CHANNELS; k++) begin
      mdl_charge[k] = '0;
      mdl_time1[k]  = '0;
      mdl_time2[k]  = '0;
    end
    mdl_count = 0;
    mdl_scan  = 1'b1;
    mdl_ovf   = 1'b0;
  endfunction

  // Buffered word i of a packet of len words, 0 outside it
  function automatic logic [31:0] model_read(int i, int len);
    if (i < 0 || i >= len || i >= MAX_WORDS) return '0;
    return mdl_words[i];
  endfunction

  function automatic void queue_record(rec_kind_t kind, int idx, logic [31:0] a,
                                       logic [31:0] b, logic [31:0] c,
                                       logic [31:0] d, bit last);
    unpacked_rec_t r;
    r.kind = kind;
    r.idx  = idx[4:0];
    r.a    = a[15:0];
    r.b    = b[15:0];
    r.c    = c[15:0];
    r.d    = d[15:0];
    r.ovf  = mdl_ovf;
    r.last = last;
    pending_records.push_back(r);
  endfunction

  // Absorb one accepted word; on the final word queue the packet's records
  function automatic void unpack_word_model(logic [31:0] w, logic eop);
    int          pos;
    int          len;
    int          i;
    int          nb;
    bit          found;
    logic [31:0] rw;
    logic [6:0]  ch;
    logic [3:0]  ty;
    pos = mdl_count;
    if (mdl_count < MAX_WORDS) begin
      mdl_words[mdl_count] = w;
      mdl_count++;
    end else begin
      mdl_ovf = 1'b1;
    end

    // channel scan, stops at the first word with a nonzero top nibble
    if (pos >= HDR_WORDS && mdl_scan) begin
      if (w[31:28] != 4'h0) begin
        mdl_scan = 1'b0;
      end else begin
        ch = w[CH_LSB +: CH_WIDTH];
        ty = w[TY_LSB +: 4];
        if (ch < CHANNELS) begin
          if (ty == TYPE_CHARGE) mdl_charge[ch] = w[15:0];
          else if (ty == TYPE_TIME1) mdl_time1[ch] = w[15:0];
          else if (ty == TYPE_TIME2) mdl_time2[ch] = w[15:0];
        end
      end
    end

    if (!eop) return;

    // userword search over the tail window
    len = mdl_count;
    i = len - SEARCH_SPAN;
    if (i < 0) i = 0;
    found = 1'b0;
    while (i < len - 2 && !found) begin
      rw = model_read(i, len);
      if (rw[USER_BIT]) found = 1'b1;
      else i++;
    end
    nb = len - i - 2;
    if (nb < 0) nb = 0;

    queue_record(KIND_HDR_A, 0, model_read(4, len), model_read(2, len),
                 model_read(1, len), model_read(0, len), 1'b0);
    queue_record(KIND_HDR_B, 0, model_read(3, len), model_read(len - 2, len),
                 model_read(len - 1, len), nb, 1'b0);
    for (int j = 0; j < CHANNELS; j++)
      queue_record(KIND_CHAN, j, 32'(mdl_charge[j]), 32'(mdl_time1[j]),
                   32'(mdl_time2[j]), 0, 1'b0);
    for (int j = 0; j < BOARD_IDS; j++)
      queue_record(KIND_BOARD, j, model_read(i + j, len), 0, 0, 0, j == BOARD_IDS - 1);
    model_clear_packet();
  endfunction

  // --------------------------------------------------------------------------
  // Record receiver: random stalls, optional long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      record_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req     <= 1'b0;
      hold_left    = HOLD_CYCLES;
      record_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      record_ready <= 1'b0;
    end else if (rx_left > 0) begin
      rx_left--;
    end else if (rx_fast) begin
      record_ready <= 1'b1;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 60) begin
        record_ready <= 1'b1;
        rx_left = $urandom_range(0, 6);
      end else if (rx_pick < 95) begin
        record_ready <= 1'b0;
        rx_left = $urandom_range(0, 3);
      end else begin
        record_ready <= 1'b0;
        rx_left = $urandom_range(10, 40);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Record checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && record_valid && record_ready) begin
      got.kind = rec_kind_t'(record_kind);
      got.idx  = index;
      got.a    = word_a;
      got.b    = word_b;
      got.c    = word_c;
      got.d    = word_d;
      got.ovf  = overflow;
      got.last = last_of_packet;
      if (pending_records.size() == 0) begin
        bad_records++;
        if (bad_records <= 10)
          $display("unexpected record: kind=%0d idx=%0d a=%h b=%h c=%h d=%h ovf=%b last=%b",
                   got.kind, got.idx, got.a, got.b, got.c, got.d, got.ovf, got.last);
      end else begin
        want = pending_records.pop_front();
        records_checked++;
        if (got !== want) begin
          bad_records++;
          if (bad_records <= 10) begin
            $display("record %0d mismatch: want kind=%0d idx=%0d a=%h b=%h c=%h d=%h ovf=%b last=%b",
                     records_checked, want.kind, want.idx, want.a, want.b, want.c,
                     want.d, want.ovf, want.last);
            $display("                     got  kind=%0d idx=%0d a=%h b=%h c=%h d=%h ovf=%b last=%b",
                     got.kind, got.idx, got.a, got.b, got.c, got.d, got.ovf, got.last);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one word, hold it until taken, then update the model
  task automatic send_word(input logic [31:0] w, input logic eop);
    int gap;
    int r;
    gap = 0;
    if (!tx_fast) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(15, 60);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      word_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_valid    <= 1'b1;
    packet_word   <= w;
    end_of_packet <= eop;
    @(posedge clk);
    while (!word_ready) @(posedge clk);
    unpack_word_model(w, eop);
    words_sent++;
  endtask

  task automatic send_packet();
    for (int k = 0; k < pkt_words.size(); k++)
      send_word(pkt_words[k], k == pkt_words.size() - 1);
    packets_sent++;
  endtask

  function automatic logic [31:0] chan_word(logic [6:0] ch, logic [3:0] ty, logic [15:0] v);
    return {4'h0, 1'b0, ch, ty, v};
  endfunction

  // Header, channel words, terminator, filler, userword + board ids, parity, summary
  task automatic build_packet(input int n_chan, input bit with_term, input int n_fill,
                              input bit with_user, input int n_user);
    logic [31:0] w;
    logic [6:0]  ch;
    logic [3:0]  ty;
    int          r;
    pkt_words.delete();
    repeat (HDR_WORDS) begin
      w = $urandom;
      if ($urandom_range(0, 3) != 0) w[USER_BIT] = 1'b0;
      pkt_words.push_back(w);
    end
    repeat (n_chan) begin
      if ($urandom_range(0, 99) < 85) ch = 7'($urandom_range(0, CHANNELS - 1));
      else ch = 7'($urandom_range(CHANNELS, 127));
      r = $urandom_range(0, 9);
      if (r < 3) ty = TYPE_CHARGE;
      else if (r < 6) ty = TYPE_TIME1;
      else if (r < 8) ty = TYPE_TIME2;
      else ty = 4'($urandom);
      w = chan_word(ch, ty, 16'($urandom));
      w[27] = 1'($urandom);
      pkt_words.push_back(w);
    end
    if (with_term) begin
      w = $urandom;
      if ($urandom_range(0, 2) != 0) w[USER_BIT] = 1'b0;
      if (w[31:28] == 4'h0) w[30] = 1'b1;
      pkt_words.push_back(w);
    end
    repeat (n_fill) begin
      w = $urandom;
      w[USER_BIT] = 1'b0;
      pkt_words.push_back(w);
    end
    if (with_user) begin
      w = $urandom;
      w[USER_BIT] = 1'b1;
      pkt_words.push_back(w);
      repeat (n_user) begin
        w = $urandom;
        w[USER_BIT] = 1'b0;
        pkt_words.push_back(w);
      end
    end
    pkt_words.push_back($urandom);
    pkt_words.push_back($urandom);
  endtask

  // Mostly well-formed packets, some cut short, some pure noise
  task automatic run_random_packets(input int budget);
    int stop_at;
    int pick;
    int cut;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        build_packet($urandom_range(0, 20), $urandom_range(0, 9) != 0,
                     $urandom_range(0, 3), $urandom_range(0, 4) != 0,
                     $urandom_range(0, 18));
        if (pick >= 70) begin
          cut = $urandom_range(1, pkt_words.size());
          while (pkt_words.size() > cut) void'(pkt_words.pop_back());
        end
      end else begin
        pkt_words.delete();
        repeat ($urandom_range(1, 12)) pkt_words.push_back($urandom);
      end
      send_packet();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // One- and two-word packets: most header and board reads fall outside the packet
  task automatic test_short_packets();
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h1234_5678, 1'b1);
    packets_sent += 2;
  endtask

  // Header extremes, the three type codes and an unknown one, channels out of range, scan stop, userwords
  task automatic test_channel_words();
    pkt_words.delete();
    pkt_words.push_back(32'hFFFF_FFFF);
    pkt_words.push_back(32'hFFFF_0000);
    pkt_words.push_back(32'h0000_FFFF);
    pkt_words.push_back(32'hEFFF_1234);
    pkt_words.push_back(32'h2000_FFFF);
    pkt_words.push_back(chan_word(7'd0,   TYPE_CHARGE, 16'hFFFF));
    pkt_words.push_back(chan_word(7'd31,  TYPE_TIME1,  16'h0001));
    pkt_words.push_back(chan_word(7'd31,  TYPE_TIME2,  16'hFFFF));
    pkt_words.push_back(chan_word(7'd32,  TYPE_CHARGE, 16'h5555));
    pkt_words.push_back(chan_word(7'd127, TYPE_TIME2,  16'hAAAA));
    pkt_words.push_back(chan_word(7'd5,   4'h3,        16'h7777));
    pkt_words.push_back(chan_word(7'd31,  TYPE_CHARGE, 16'h8001));
    pkt_words.push_back(chan_word(7'd7,   TYPE_TIME1,  16'h4321) | 32'h0800_0000);
    pkt_words.push_back(32'h2000_0000);
    // past the scan stop: must not land in the tables
    pkt_words.push_back(chan_word(7'd1,   TYPE_CHARGE, 16'h1111));
    pkt_words.push_back(32'h1000_0003);
    pkt_words.push_back(32'h0000_B001);
    pkt_words.push_back(32'h0000_B002);
    pkt_words.push_back(32'hE000_B003);
    pkt_words.push_back(32'h0000_AAAA);
    pkt_words.push_back(32'hFFFF_5555);
    send_packet();
  endtask

  task automatic test_random_packets();
    run_random_packets(80);
  endtask

  // Back-to-back words and an always-ready receiver
  task automatic test_no_idle();
    tx_fast = 1'b1;
    rx_fast <= 1'b1;
    run_random_packets(25);
    tx_fast = 1'b0;
    rx_fast <= 1'b0;
  endtask

  // Receiver holds off while words keep coming, so the input backs up
  task automatic test_backpressure();
    hold_req <= 1'b1;
    run_random_packets(30);
  endtask

  // Words past a full buffer, with the channel scan running past the buffer end
  task automatic test_overflow();
    build_packet(124, 1'b0, 0, 1'b0, 0);
    send_packet();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < MAX_WORDS; k++) mdl_words[k] = '0;
    model_clear_packet();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_packets();
    test_channel_words();
    test_random_packets();
    test_no_idle();
    test_backpressure();
    test_overflow();

    word_valid    <= 1'b0;
    end_of_packet <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d packets, %0d words in, %0d records checked",
             packets_sent, words_sent, records_checked);
    $display("short, truncated and noise packets, stray channels, overflow, long stall");
    if (bad_records == 0 && pending_records.size() == 0) begin
      $display("PASS readout_packet_unpacker");
    end else begin
      $display("%0d bad records, %0d left outstanding", bad_records, pending_records.size());
      $display("FAIL readout_packet_unpacker");
    end
    $finish;
  end

endmodule

>>> readout_packet_unpacker.f
hdl/rpu_pkg.sv
hdl/rpu_datapath.sv
hdl/rpu_ctrl.sv
hdl/readout_packet_unpacker.sv
bench/tb_readout_packet_unpacker.sv
